// File: hdl/ordered_list_insert_remove_macros.svh
// ----------------------------------------------------------------------------
// Ordered list assertion macros
// Shared property forms for the ordered list block, clocked on clock and
// switched off during reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_REMOVE_MACROS_SVH
`define ORDERED_LIST_INSERT_REMOVE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define OLIR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define OLIR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/olir_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list package
// Sizes, command and status codes, and the control bundle sent to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package olir_pkg;

   localparam int CAPACITY     = 16;
   localparam int ELEMENT_BITS = 32;
   localparam int IDX_BITS     = $clog2(CAPACITY);
   localparam int COUNT_BITS   = $clog2(CAPACITY + 1);

   localparam int CMD_BITS     = 3;
   localparam int POS_BITS     = 4;
   localparam int VALUE_BITS   = 32;
   localparam int STATUS_BITS  = 2;

   localparam logic [CMD_BITS-1:0] CMD_APPEND = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_INSERT = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_REMOVE = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_READ   = 3'd4;

   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

   // Broadcast to every cell for the item being accepted.
   typedef struct packed {
      logic                    append_go;
      logic                    insert_go;
      logic                    remove_go;
      logic [COUNT_BITS-1:0]   pos;
      logic [COUNT_BITS-1:0]   count;
      logic [ELEMENT_BITS-1:0] value;
   } cell_ctl_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]  count;
      logic [STATUS_BITS-1:0] status;
      logic                   read_go;
   } ctl_rsp_type;

endpackage

`default_nettype wire

// File: hdl/olir_cell.sv
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one entry; takes its lower neighbor's entry on insert, its upper
// neighbor's entry on remove, or the new element at its own slot.
// ----------------------------------------------------------------------------
`default_nettype none

module olir_cell
   import olir_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic [IDX_BITS-1:0]     cell_index,
   input  wire cell_ctl_type            ctl,
   input  wire logic [ELEMENT_BITS-1:0] prev_entry,
   input  wire logic [ELEMENT_BITS-1:0] next_entry,
   output logic      [ELEMENT_BITS-1:0] entry
);

   logic [ELEMENT_BITS-1:0] entry_ff;
   logic [ELEMENT_BITS-1:0] entry_in;
   logic [COUNT_BITS-1:0]   idx;
   logic [COUNT_BITS-1:0]   idx_up;

   assign idx    = COUNT_BITS'(cell_index);
   assign idx_up = idx + COUNT_BITS'(1);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.append_go && idx == ctl.count) begin
         entry_in = ctl.value;
      end else if (ctl.insert_go) begin
         if (idx == ctl.pos) begin
            entry_in = ctl.value;
         end else if (idx > ctl.pos && idx <= ctl.count) begin
            entry_in = prev_entry;
         end
      end else if (ctl.remove_go) begin
         if (idx >= ctl.pos && idx_up < ctl.count) begin
            entry_in = next_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// File: hdl/olir_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered list controller
// Keeps the entry count, checks range and fullness, and drives the cells.
// ----------------------------------------------------------------------------
`default_nettype none

module olir_ctrl
   import olir_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire logic [CMD_BITS-1:0]     command,
   input  wire logic [POS_BITS-1:0]     position,
   input  wire logic [ELEMENT_BITS-1:0] value,
   output cell_ctl_type                 cell_ctl,
   output ctl_rsp_type                  rsp
);

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [COUNT_BITS-1:0] pos_ext;
   logic                  in_range;
   logic                  full;
   logic                  append_ok;
   logic                  insert_ok;
   logic                  remove_ok;
   logic [STATUS_BITS-1:0] status;
   logic                  read_ok;

   assign pos_ext  = COUNT_BITS'(position);
   assign in_range = pos_ext < count_ff;
   assign full     = count_ff == COUNT_BITS'(CAPACITY);

   always_comb begin
      append_ok = 1'b0;
      insert_ok = 1'b0;
      remove_ok = 1'b0;
      read_ok   = 1'b0;
      status    = ST_OK;
      count_in  = count_ff;
      case (command)
         CMD_APPEND: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               append_ok = 1'b1;
               count_in  = count_ff + COUNT_BITS'(1);
            end
         end
         CMD_INSERT: begin
            // The range check wins over the full check.
            if (!in_range) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               insert_ok = 1'b1;
               count_in  = count_ff + COUNT_BITS'(1);
            end
         end
         CMD_REMOVE: begin
            if (!in_range) begin
               status = ST_RANGE;
            end else begin
               remove_ok = 1'b1;
               count_in  = count_ff - COUNT_BITS'(1);
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         CMD_READ: begin
            if (!in_range) begin
               status = ST_RANGE;
            end else begin
               read_ok = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   assign cell_ctl.append_go = accept && append_ok;
   assign cell_ctl.insert_go = accept && insert_ok;
   assign cell_ctl.remove_go = accept && remove_ok;
   assign cell_ctl.pos       = pos_ext;
   assign cell_ctl.count     = count_ff;
   assign cell_ctl.value     = value;

   assign rsp.count   = count_in;
   assign rsp.status  = status;
   assign rsp.read_go = read_ok;

endmodule

`default_nettype wire

// File: hdl/ordered_list_insert_remove.sv
// ----------------------------------------------------------------------------
// Ordered list with insert and remove
// A fixed row of entry cells with append, insert, remove, clear and read.
// ----------------------------------------------------------------------------
//   Channel  Direction  tdata (low bit up)                      tuser
//   req      in         position[3:0], element_value[35:4]      command
//   rsp      out        read_value[31:0], entry_count[36:32]    status
//
// All cells shift in parallel in the cycle the item is accepted, and the
// result is registered in the output register.
// A new item is taken each cycle while the output register is empty or drained.
// Reset empties the list; entry contents are not cleared.
// A stalled result holds the output register and blocks further items.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_insert_remove
   import olir_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // position, element_value, zero pad
   input  wire logic [2:0]  req_tuser,   // command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata,   // read_value, entry_count, zero pad
   output logic      [1:0]  rsp_tuser    // status
);

`include "ordered_list_insert_remove_macros.svh"

   logic                    req_accept;
   logic [CMD_BITS-1:0]     command;
   logic [POS_BITS-1:0]     position;
   logic [ELEMENT_BITS-1:0] value;
   cell_ctl_type            cell_ctl;
   ctl_rsp_type             ctl_rsp;
   logic [ELEMENT_BITS-1:0] entry [CAPACITY];
   logic [ELEMENT_BITS-1:0] read_mux;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [VALUE_BITS-1:0]   read_value_ff;
   logic [VALUE_BITS-1:0]   read_value_in;
   logic [COUNT_BITS-1:0]   count_ff;
   logic [STATUS_BITS-1:0]  status_ff;

   assign command    = req_tuser;
   assign position   = req_tdata[POS_BITS-1:0];
   assign value      = req_tdata[POS_BITS +: ELEMENT_BITS];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   olir_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .command  (command),
      .position (position),
      .value    (value),
      .cell_ctl (cell_ctl),
      .rsp      (ctl_rsp)
   );

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      olir_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_BITS'(k)),
         .ctl        (cell_ctl),
         .prev_entry ((k == 0) ? '0 : entry[(k == 0) ? 0 : k - 1]),
         .next_entry ((k == CAPACITY - 1) ? '0 : entry[(k == CAPACITY - 1) ? k : k + 1]),
         .entry      (entry[k])
      );
   end

   // Each cell drives the read bus only when its index matches the position.
   always_comb begin
      read_mux = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         if (cell_ctl.pos == COUNT_BITS'(k)) begin
            read_mux = read_mux | entry[k];
         end
      end
   end

   assign read_value_in = ctl_rsp.read_go ? VALUE_BITS'(read_mux) : '0;
   assign rsp_valid_in  = req_accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_accept) begin
         read_value_ff <= read_value_in;
         count_ff      <= ctl_rsp.count;
         status_ff     <= ctl_rsp.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, count_ff, read_value_ff};
   assign rsp_tuser  = status_ff;

   `OLIR_ASSERT_NOW(a_count_bound, 1'b1, cell_ctl.count <= COUNT_BITS'(CAPACITY),
                    "count above capacity")
   `OLIR_ASSERT_NEXT(a_rsp_follows, req_accept, rsp_tvalid,
                     "accepted item gave no result")
   `OLIR_ASSERT_NEXT(a_clear_empties, req_accept && command == CMD_CLEAR,
                     cell_ctl.count == '0, "clear left entries")
   `OLIR_ASSERT_NOW(a_full_only_full, req_accept && ctl_rsp.status == ST_FULL,
                    cell_ctl.count == COUNT_BITS'(CAPACITY),
                    "full status on a list with room")

endmodule

`default_nettype wire

// File: tb/tb_ordered_list_insert_remove.sv
// ----------------------------------------------------------------------------
// Ordered list testbench
// Drives append, insert, remove, clear and read items into the list, first
// from a short table of corner cases and then at random. An internal copy of
// the list predicts each result the table does not give, and both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ordered_list_insert_remove;
   import olir_pkg::*;

   // Command codes the block ignores.
   localparam logic [CMD_BITS-1:0] CMD_RESERVED_LO = 3'd5;
   localparam logic [CMD_BITS-1:0] CMD_RESERVED_MID = 3'd6;
   localparam logic [CMD_BITS-1:0] CMD_RESERVED_HI = 3'd7;

   localparam int RANDOM_ITEMS = 925;
   localparam int QUIET_ITEMS  = 150;
   localparam int DRAIN_CYCLES = 10;
   localparam int STALL_LIMIT  = 2000;

   typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIXED} list_mode_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0]  read_value;
      logic [COUNT_BITS-1:0]  entry_count;
      logic [STATUS_BITS-1:0] status;
   } list_result_type;

   typedef struct packed {
      logic [CMD_BITS-1:0]   cmd;
      logic [POS_BITS-1:0]   pos;
      logic [VALUE_BITS-1:0] value;
      logic                  typed;
      list_result_type       want;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // position, element_value, zero pad
   logic [2:0]  req_tuser  = '0;   // command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // read_value, entry_count, zero pad
   logic [1:0]  rsp_tuser;         // status

   // Predicted contents of the list.
   logic [ELEMENT_BITS-1:0] list_mem [CAPACITY];
   int                      list_count = 0;

   list_result_type pending_results[$];
   list_result_type oldest;
   int              fail_count  = 0;
   int              idle_cycles = 0;
   int              stall_left  = 0;
   bit              quiet       = 1'b0;
   int              cmd_seen [8];
   int              status_seen [4];

   ordered_list_insert_remove dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   function automatic list_result_type apply_list_cmd(input logic [CMD_BITS-1:0] cmd,
                                                      input logic [POS_BITS-1:0] pos,
                                                      input logic [VALUE_BITS-1:0] value);
      list_result_type r;
      int i;
      r = '0;
      case (cmd)
         CMD_APPEND: begin
            if (list_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               list_mem[list_count] = value;
               list_count++;
            end
         end
         CMD_INSERT: begin
            // The range test wins over the full test.
            if (pos >= list_count) begin
               r.status = ST_RANGE;
            end else if (list_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               for (i = list_count; i > pos; i--)
                  list_mem[i] = list_mem[i-1];
               list_mem[pos] = value;
               list_count++;
            end
         end
         CMD_REMOVE: begin
            if (pos >= list_count) begin
               r.status = ST_RANGE;
            end else begin
               for (i = pos + 1; i < list_count; i++)
                  list_mem[i-1] = list_mem[i];
               list_count--;
            end
         end
         CMD_CLEAR: begin
            list_count = 0;
         end
         CMD_READ: begin
            if (pos >= list_count)
               r.status = ST_RANGE;
            else
               r.read_value = list_mem[pos];
         end
         default: begin
         end
      endcase
      r.entry_count = COUNT_BITS'(list_count);
      return r;
   endfunction

   function automatic stim_row_type make_row(input logic [CMD_BITS-1:0] cmd,
                                             input logic [POS_BITS-1:0] pos,
                                             input logic [VALUE_BITS-1:0] value,
                                             input logic typed,
                                             input logic [VALUE_BITS-1:0] read_value,
                                             input logic [COUNT_BITS-1:0] entry_count,
                                             input logic [STATUS_BITS-1:0] status);
      stim_row_type row;
      row.cmd              = cmd;
      row.pos              = pos;
      row.value            = value;
      row.typed            = typed;
      row.want.read_value  = read_value;
      row.want.entry_count = entry_count;
      row.want.status      = status;
      return row;
   endfunction

   // Presents one item, waits for it to be taken and records its result.
   task automatic send_item(input logic [CMD_BITS-1:0] cmd, input logic [POS_BITS-1:0] pos,
                            input logic [VALUE_BITS-1:0] value, input logic typed,
                            input list_result_type want);
      list_result_type predicted;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, value, pos};
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predicted = apply_list_cmd(cmd, pos, value);
      pending_results.push_back(typed ? want : predicted);
      cmd_seen[cmd]++;
   endtask

   // Result side: checks each result and stalls in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            status_seen[rsp_tuser]++;
            if (pending_results.size() == 0) begin
               $error("result item arrived with nothing expected");
               fail_count++;
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_tdata[31:0] !== oldest.read_value) begin
                  $error("read_value mismatch: expected %h, got %h",
                         oldest.read_value, rsp_tdata[31:0]);
                  fail_count++;
               end
               if (rsp_tdata[36:32] !== oldest.entry_count) begin
                  $error("entry_count mismatch: expected %0d, got %0d",
                         oldest.entry_count, rsp_tdata[36:32]);
                  fail_count++;
               end
               if (rsp_tuser !== oldest.status) begin
                  $error("status mismatch: expected %0d, got %0d", oldest.status, rsp_tuser);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Ends the run if neither channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("ordered_list_insert_remove verification failed");
         $finish;
      end
   end

   initial begin
      stim_row_type         directed_rows[$];
      list_mode_type        mode;
      logic [CMD_BITS-1:0]  cmd;
      logic [POS_BITS-1:0]  pos;
      int                   grow;
      int                   roll;
      int                   proll;
      int                   n;

      mode = MODE_MIXED;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Empty list first, then a short list with both value extremes.
      directed_rows.push_back(make_row(CMD_READ,   4'd0,  '0, 1'b1, '0, 5'd0, ST_RANGE));
      directed_rows.push_back(make_row(CMD_REMOVE, 4'd0,  '0, 1'b1, '0, 5'd0, ST_RANGE));
      directed_rows.push_back(make_row(CMD_INSERT, 4'd0,  32'h0000_0001, 1'b1, '0, 5'd0,
                                       ST_RANGE));
      directed_rows.push_back(make_row(CMD_READ,   4'd15, '0, 1'b1, '0, 5'd0, ST_RANGE));
      directed_rows.push_back(make_row(CMD_CLEAR,  4'd0,  '0, 1'b1, '0, 5'd0, ST_OK));
      directed_rows.push_back(make_row(CMD_APPEND, 4'd0,  32'hFFFF_FFFF, 1'b1, '0, 5'd1,
                                       ST_OK));
      directed_rows.push_back(make_row(CMD_READ,   4'd0,  '0, 1'b1, 32'hFFFF_FFFF, 5'd1,
                                       ST_OK));
      directed_rows.push_back(make_row(CMD_APPEND, 4'd0,  '0, 1'b1, '0, 5'd2, ST_OK));
      directed_rows.push_back(make_row(CMD_INSERT, 4'd0,  32'h1234_5678, 1'b0, '0, '0, '0));
      // Insert at exactly the entry count is out of range.
      directed_rows.push_back(make_row(CMD_INSERT, 4'd3,  32'h5555_5555, 1'b1, '0, 5'd3,
                                       ST_RANGE));
      directed_rows.push_back(make_row(CMD_INSERT, 4'd1,  32'hA5A5_A5A5, 1'b0, '0, '0, '0));
      directed_rows.push_back(make_row(CMD_READ,   4'd0,  '0, 1'b0, '0, '0, '0));
      directed_rows.push_back(make_row(CMD_READ,   4'd1,  '0, 1'b0, '0, '0, '0));
      directed_rows.push_back(make_row(CMD_READ,   4'd2,  '0, 1'b0, '0, '0, '0));
      directed_rows.push_back(make_row(CMD_READ,   4'd3,  '0, 1'b0, '0, '0, '0));
      directed_rows.push_back(make_row(CMD_READ,   4'd4,  '0, 1'b1, '0, 5'd4, ST_RANGE));
      directed_rows.push_back(make_row(CMD_REMOVE, 4'd3,  '0, 1'b0, '0, '0, '0));
      directed_rows.push_back(make_row(CMD_REMOVE, 4'd0,  '0, 1'b0, '0, '0, '0));
      directed_rows.push_back(make_row(CMD_READ,   4'd0,  '0, 1'b0, '0, '0, '0));
      directed_rows.push_back(make_row(CMD_READ,   4'd1,  '0, 1'b0, '0, '0, '0));
      directed_rows.push_back(make_row(CMD_RESERVED_LO, 4'd15, 32'hFFFF_FFFF, 1'b1, '0, 5'd2,
                                       ST_OK));
      directed_rows.push_back(make_row(CMD_RESERVED_HI, 4'd1, '0, 1'b1, '0, 5'd2, ST_OK));
      directed_rows.push_back(make_row(CMD_REMOVE, 4'd15, '0, 1'b1, '0, 5'd2, ST_RANGE));
      directed_rows.push_back(make_row(CMD_CLEAR,  4'd0,  '0, 1'b1, '0, 5'd0, ST_OK));
      directed_rows.push_back(make_row(CMD_READ,   4'd0,  '0, 1'b1, '0, 5'd0, ST_RANGE));

      foreach (directed_rows[i])
         send_item(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].want);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // Phases that push the list toward full or empty, or hold it in between.
         if (n % 40 == 0)
            mode = list_mode_type'($urandom_range(0, 2));
         if (n == RANDOM_ITEMS - QUIET_ITEMS)
            quiet = 1'b1;
         if (n == RANDOM_ITEMS / 2) begin
            req_tvalid <= 1'b0;
            do
               @(posedge clock);
            while (pending_results.size() != 0);
         end

         case (mode)
            MODE_FILL:  grow = 70;
            MODE_DRAIN: grow = 15;
            default:    grow = 40;
         endcase
         roll = $urandom_range(0, 99);
         if (roll < 2)
            cmd = CMD_CLEAR;
         else if (roll < 5)
            cmd = CMD_BITS'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
         else if (roll < 5 + grow)
            cmd = ($urandom_range(0, 2) == 0) ? CMD_INSERT : CMD_APPEND;
         else if (roll < 25 + grow)
            cmd = CMD_READ;
         else
            cmd = CMD_REMOVE;

         // Mostly valid positions, some exactly at the count, some anywhere.
         proll = $urandom_range(0, 9);
         if (list_count > 0 && proll < 7)
            pos = POS_BITS'($urandom_range(0, list_count - 1));
         else if (proll < 8)
            pos = POS_BITS'(list_count);
         else
            pos = POS_BITS'($urandom_range(0, 15));

         send_item(cmd, pos, $urandom(), 1'b0, '0);

         if (!quiet && $urandom_range(0, 7) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d appends, %0d inserts, %0d removes, %0d clears, %0d reads, %0d ignored.",
               cmd_seen[CMD_APPEND], cmd_seen[CMD_INSERT], cmd_seen[CMD_REMOVE],
               cmd_seen[CMD_CLEAR], cmd_seen[CMD_READ],
               cmd_seen[CMD_RESERVED_LO] + cmd_seen[CMD_RESERVED_MID] +
               cmd_seen[CMD_RESERVED_HI]);
      $display("Results seen: %0d ok, %0d out of range, %0d list full.",
               status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL]);
      if (fail_count == 0)
         $display("ordered_list_insert_remove verification clean");
      else
         $display("ordered_list_insert_remove verification failed");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/olir_pkg.sv
hdl/olir_cell.sv
hdl/olir_ctrl.sv
hdl/ordered_list_insert_remove.sv
tb/tb_ordered_list_insert_remove.sv
